>>> hw/rtl/mwsa_pkg.sv
`default_nettype none

package mwsa_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int PAGE_BITS  = 12;

    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int IDX_W      = WADDR_W + BIT_W;
    localparam int CUR_W      = IDX_W + 1;

    localparam int ADDR_W       = 32;
    localparam int FRAME_W      = 20;
    localparam int FLAGS_W      = 12;
    localparam int STATUS_W     = 2;
    localparam int SLOT_FIELD_W = 10;
    localparam int CFG_DATA_W   = 32;
    localparam int PAGE_NUM_W   = ADDR_W - PAGE_BITS;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

    localparam logic ACT_MAP   = 1'b0;
    localparam logic ACT_UNMAP = 1'b1;

    localparam logic REG_WINDOW_BASE = 1'b0;
    localparam logic REG_ENTRY_FLAGS = 1'b1;

    typedef struct packed {
        logic                 rd_en;
        logic [WADDR_W-1:0]   rd_addr;
        logic                 wr_en;
        logic [WADDR_W-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } bmap_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/mwsa_ram.sv
`default_nettype none

module mwsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]      wr_data,
    input  wire logic                  rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mwsa_bmap.sv
`default_nettype none

module mwsa_bmap
    import mwsa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bmap_req_t            req,
    output logic      [WORD_BITS-1:0] rd_data
);

    logic [WORD_COUNT-1:0] vld_reg;
    logic [WORD_COUNT-1:0] vld_next;
    logic                  rd_vld_reg;
    logic                  rd_vld_next;
    logic [WORD_BITS-1:0]  ram_q;

    mwsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    // words never written read as zero
    always_comb
    begin
        vld_next = vld_reg;
        if (req.wr_en)
        begin
            vld_next[req.wr_addr] = 1'b1;
        end
        rd_vld_next = req.rd_en ? vld_reg[req.rd_addr] : rd_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= vld_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    assign rd_data = rd_vld_reg ? ram_q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/mwsa_scan.sv
`default_nettype none

module mwsa_scan
    import mwsa_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] used_word,
    input  wire logic [WADDR_W-1:0]   waddr,
    input  wire logic [BIT_W-1:0]     start_bit,
    output logic                      found,
    output logic      [BIT_W-1:0]     bit_idx
);

    logic [WORD_BITS-1:0] cand;

    // free bits at or after start_bit that lie inside the window
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            cand[b] = !used_word[b]
                      && (BIT_W'(b) >= start_bit)
                      && ({1'b0, waddr, BIT_W'(b)} < CUR_W'(SLOT_COUNT));
        end
    end

    // lowest candidate wins
    always_comb
    begin
        found   = 1'b0;
        bit_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                found   = 1'b1;
                bit_idx = BIT_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/map_window_slot_allocator.sv
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+------------------------------
// request   | action, page_frame, unmap_address         | start high while busy low
// result    | status, slot, virtual_address, entry_value| done high for one cycle
// config    | cfg_index, cfg_data                       | cfg_write high, no wait
//
// map: each word from the cursor word to the last word is read, then scanned; if
//   nothing is free, a reclaim pass over every word, then a rescan from word 0.
// unmap: read-modify-write of the garbage word; out of window: answered from idle.
// done comes the cycle after the last step; the pace is set by the single
// registered read port of each bitmap memory and the one shared word scanner.
// reset clears both bitmaps at once through per-word valid bits; no clearing pass.
// results cannot be held off by the receiver; busy stays high until done is issued.
`default_nettype none

module map_window_slot_allocator
    import mwsa_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    action,
    input  wire logic [FRAME_W-1:0]      page_frame,
    input  wire logic [ADDR_W-1:0]       unmap_address,
    output logic                         done,
    output logic      [STATUS_W-1:0]     status,
    output logic      [SLOT_FIELD_W-1:0] slot,
    output logic      [ADDR_W-1:0]       virtual_address,
    output logic      [ADDR_W-1:0]       entry_value,
    input  wire logic                    cfg_write,
    input  wire logic                    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SRCH_RD  = 7'b0000010,
        S_SRCH_CHK = 7'b0000100,
        S_RCL_RD   = 7'b0001000,
        S_RCL_WR   = 7'b0010000,
        S_UNM_RD   = 7'b0100000,
        S_UNM_WR   = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [WADDR_W-1:0]      waddr_reg, waddr_next;
    logic [BIT_W-1:0]        sbit_reg, sbit_next;
    logic                    reclaimed_reg, reclaimed_next;
    logic [CUR_W-1:0]        cursor_reg, cursor_next;
    logic [FRAME_W-1:0]      frame_reg, frame_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [IDX_W-1:0]        uslot_reg, uslot_next;
    logic [ADDR_W-1:0]       wbase_reg, wbase_next;
    logic [FLAGS_W-1:0]      flags_reg, flags_next;
    logic                    done_reg, done_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [SLOT_FIELD_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0]       va_reg, va_next;
    logic [ADDR_W-1:0]       entry_reg, entry_next;

    bmap_req_t               used_req;
    bmap_req_t               garb_req;
    logic [WORD_BITS-1:0]    used_word;
    logic [WORD_BITS-1:0]    garb_word;

    logic                    scan_found;
    logic [BIT_W-1:0]        scan_bit;

    logic                    accept;
    logic [ADDR_W-1:0]       unmap_off;
    logic [PAGE_NUM_W-1:0]   unmap_page;
    logic                    unmap_out;
    logic [IDX_W-1:0]        found_idx;
    logic                    last_word;
    logic                    cursor_at_end;
    logic [ADDR_W-1:0]       map_va;
    logic [ADDR_W-1:0]       map_entry;

    mwsa_bmap u_used (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (used_req),
        .rd_data (used_word)
    );

    mwsa_bmap u_garb (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (garb_req),
        .rd_data (garb_word)
    );

    mwsa_scan u_scan (
        .used_word (used_word),
        .waddr     (waddr_reg),
        .start_bit (sbit_reg),
        .found     (scan_found),
        .bit_idx   (scan_bit)
    );

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start && !busy;
    assign unmap_off     = unmap_address - wbase_reg;
    assign unmap_page    = unmap_off[ADDR_W-1:PAGE_BITS];
    assign unmap_out     = unmap_page >= PAGE_NUM_W'(SLOT_COUNT);
    assign found_idx     = {waddr_reg, scan_bit};
    assign last_word     = waddr_reg == WADDR_W'(WORD_COUNT - 1);
    assign cursor_at_end = cursor_reg >= CUR_W'(SLOT_COUNT);
    assign map_va        = wbase_reg + (ADDR_W'(found_idx) << PAGE_BITS);
    assign map_entry     = ADDR_W'({frame_reg, {PAGE_BITS{1'b0}}}) | ADDR_W'(flags_reg);

    always_comb
    begin
        state_next     = state_reg;
        waddr_next     = waddr_reg;
        sbit_next      = sbit_reg;
        reclaimed_next = reclaimed_reg;
        cursor_next    = cursor_reg;
        frame_next     = frame_reg;
        addr_next      = addr_reg;
        uslot_next     = uslot_reg;
        wbase_next     = wbase_reg;
        flags_next     = flags_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        slot_next      = slot_reg;
        va_next        = va_reg;
        entry_next     = entry_reg;
        used_req       = '0;
        garb_req       = '0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW_BASE: wbase_next = cfg_data;
                REG_ENTRY_FLAGS: flags_next = cfg_data[FLAGS_W-1:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    frame_next     = page_frame;
                    addr_next      = unmap_address;
                    reclaimed_next = 1'b0;
                    sbit_next      = '0;
                    if (action == ACT_MAP)
                    begin
                        if (cursor_at_end)
                        begin
                            waddr_next = '0;
                            state_next = S_RCL_RD;
                        end
                        else
                        begin
                            waddr_next = cursor_reg[IDX_W-1:BIT_W];
                            sbit_next  = cursor_reg[BIT_W-1:0];
                            state_next = S_SRCH_RD;
                        end
                    end
                    else if (unmap_out)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_OUTSIDE;
                        slot_next   = '0;
                        va_next     = unmap_address;
                        entry_next  = '0;
                    end
                    else
                    begin
                        uslot_next = IDX_W'(unmap_page);
                        state_next = S_UNM_RD;
                    end
                end
            end

            S_SRCH_RD:
            begin
                used_req.rd_en   = 1'b1;
                used_req.rd_addr = waddr_reg;
                state_next       = S_SRCH_CHK;
            end

            S_SRCH_CHK:
            begin
                if (scan_found)
                begin
                    used_req.wr_en   = 1'b1;
                    used_req.wr_addr = waddr_reg;
                    used_req.wr_data = used_word | (WORD_BITS'(1) << scan_bit);
                    cursor_next      = CUR_W'(found_idx) + CUR_W'(1);
                    done_next        = 1'b1;
                    status_next      = STATUS_OK;
                    slot_next        = SLOT_FIELD_W'(found_idx);
                    va_next          = map_va;
                    entry_next       = map_entry;
                    state_next       = S_IDLE;
                end
                else if (!last_word)
                begin
                    waddr_next = waddr_reg + WADDR_W'(1);
                    sbit_next  = '0;
                    state_next = S_SRCH_RD;
                end
                else if (reclaimed_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_FULL;
                    slot_next   = '0;
                    va_next     = '0;
                    entry_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    waddr_next = '0;
                    state_next = S_RCL_RD;
                end
            end

            S_RCL_RD:
            begin
                used_req.rd_en   = 1'b1;
                used_req.rd_addr = waddr_reg;
                garb_req.rd_en   = 1'b1;
                garb_req.rd_addr = waddr_reg;
                state_next       = S_RCL_WR;
            end

            S_RCL_WR:
            begin
                used_req.wr_en   = 1'b1;
                used_req.wr_addr = waddr_reg;
                used_req.wr_data = used_word & ~garb_word;
                garb_req.wr_en   = 1'b1;
                garb_req.wr_addr = waddr_reg;
                garb_req.wr_data = '0;
                sbit_next        = '0;
                if (last_word)
                begin
                    reclaimed_next = 1'b1;
                    waddr_next     = '0;
                    state_next     = S_SRCH_RD;
                end
                else
                begin
                    waddr_next = waddr_reg + WADDR_W'(1);
                    state_next = S_RCL_RD;
                end
            end

            S_UNM_RD:
            begin
                garb_req.rd_en   = 1'b1;
                garb_req.rd_addr = uslot_reg[IDX_W-1:BIT_W];
                state_next       = S_UNM_WR;
            end

            S_UNM_WR:
            begin
                garb_req.wr_en   = 1'b1;
                garb_req.wr_addr = uslot_reg[IDX_W-1:BIT_W];
                garb_req.wr_data = garb_word | (WORD_BITS'(1) << uslot_reg[BIT_W-1:0]);
                done_next        = 1'b1;
                status_next      = STATUS_OK;
                slot_next        = SLOT_FIELD_W'(uslot_reg);
                va_next          = addr_reg;
                entry_next       = '0;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            wbase_reg  <= '0;
            flags_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            wbase_reg  <= wbase_next;
            flags_reg  <= flags_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg     <= waddr_next;
        sbit_reg      <= sbit_next;
        reclaimed_reg <= reclaimed_next;
        frame_reg     <= frame_next;
        addr_reg      <= addr_next;
        uslot_reg     <= uslot_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        va_reg        <= va_next;
        entry_reg     <= entry_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign slot            = slot_reg;
    assign virtual_address = va_reg;
    assign entry_value     = entry_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mwsa_checker.sv
`default_nettype none

module mwsa_checker
    import mwsa_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic                    action,
    input wire logic                    done,
    input wire logic [STATUS_W-1:0]     status,
    input wire logic [SLOT_FIELD_W-1:0] slot,
    input wire logic [ADDR_W-1:0]       virtual_address,
    input wire logic [ADDR_W-1:0]       entry_value
);

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_FULL |->
            slot == '0 && virtual_address == '0 && entry_value == '0)
        else $error("full result carries nonzero fields");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_OUTSIDE |-> slot == '0 && entry_value == '0)
        else $error("outside result carries nonzero slot or entry");

    a_map_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == ACT_MAP |=> !done)
        else $error("map request finished in one cycle");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while still busy");

endmodule

bind map_window_slot_allocator mwsa_checker u_checker (.*);

`default_nettype wire

>>> test/tb_map_window_slot_allocator.sv
`timescale 1ns / 100ps

module tb_map_window_slot_allocator;
    import mwsa_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ADDR_W-1:0]       vaddr;
        logic [ADDR_W-1:0]       entry;
    } map_result_t;

    class slot_window_tracker;
        logic [ADDR_W-1:0]     base;
        logic [FLAGS_W-1:0]    flags;
        logic [SLOT_COUNT-1:0] in_use;
        logic [SLOT_COUNT-1:0] released;
        int                    cursor;
        int                    full_hits;
        int                    failures;
        int                    live_slots[$];
        map_result_t           awaited[$];

        function new();
            base      = '0;
            flags     = '0;
            in_use    = '0;
            released  = '0;
            cursor    = 0;
            full_hits = 0;
            failures  = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_WINDOW_BASE)
                base = data;
            else
                flags = data[FLAGS_W-1:0];
        endfunction

        function int first_free(int from);
            for (int i = from; i < SLOT_COUNT; i++)
                if (!in_use[i])
                    return i;
            return SLOT_COUNT;
        endfunction

        function int take_live();
            int k;
            int s;
            if (live_slots.size() == 0)
                return $urandom_range(SLOT_COUNT - 1);
            k = $urandom_range(live_slots.size() - 1);
            s = live_slots[k];
            live_slots.delete(k);
            return s;
        endfunction

        // next-fit search, reclaim of released slots on a miss
        function void accept_request(logic act, logic [FRAME_W-1:0] frame,
                                     logic [ADDR_W-1:0] addr);
            map_result_t r;
            int idx;
            logic [ADDR_W-1:0] offset;
            r = '0;
            if (act == ACT_MAP)
            begin
                idx = first_free(cursor);
                if (idx >= SLOT_COUNT)
                begin
                    in_use   = in_use & ~released;
                    released = '0;
                    idx      = first_free(0);
                end
                if (idx >= SLOT_COUNT)
                begin
                    r.status = STATUS_FULL;
                    full_hits++;
                end
                else
                begin
                    in_use[idx] = 1'b1;
                    cursor      = idx + 1;
                    r.status    = STATUS_OK;
                    r.slot      = idx[SLOT_FIELD_W-1:0];
                    r.vaddr     = base + (ADDR_W'(idx) << PAGE_BITS);
                    r.entry     = (ADDR_W'(frame) << PAGE_BITS) | ADDR_W'(flags);
                    live_slots.push_back(idx);
                end
            end
            else
            begin
                offset  = addr - base;
                r.vaddr = addr;
                if ((offset >> PAGE_BITS) >= SLOT_COUNT)
                    r.status = STATUS_OUTSIDE;
                else
                begin
                    idx           = int'(offset >> PAGE_BITS);
                    released[idx] = 1'b1;
                    r.status      = STATUS_OK;
                    r.slot        = idx[SLOT_FIELD_W-1:0];
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_result(map_result_t got);
            map_result_t exp;
            if (awaited.size() == 0)
            begin
                $display("%0t unexpected result: status %0d slot %0d va %h entry %h",
                         $time, got.status, got.slot, got.vaddr, got.entry);
                failures++;
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status)
            begin
                $display("%0t status: expected %0d, got %0d", $time, exp.status, got.status);
                failures++;
            end
            if (got.slot !== exp.slot)
            begin
                $display("%0t slot: expected %0d, got %0d", $time, exp.slot, got.slot);
                failures++;
            end
            if (got.vaddr !== exp.vaddr)
            begin
                $display("%0t virtual_address: expected %h, got %h", $time, exp.vaddr, got.vaddr);
                failures++;
            end
            if (got.entry !== exp.entry)
            begin
                $display("%0t entry_value: expected %h, got %h", $time, exp.entry, got.entry);
                failures++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    action;
    logic [FRAME_W-1:0]      page_frame;
    logic [ADDR_W-1:0]       unmap_address;
    logic                    done;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ADDR_W-1:0]       virtual_address;
    logic [ADDR_W-1:0]       entry_value;
    logic                    cfg_write;
    logic                    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    slot_window_tracker sb;
    bit                 idle_on;
    int                 cycle_count;

    map_window_slot_allocator uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .page_frame      (page_frame),
        .unmap_address   (unmap_address),
        .done            (done),
        .status          (status),
        .slot            (slot),
        .virtual_address (virtual_address),
        .entry_value     (entry_value),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(map_result_t'({status, slot, virtual_address, entry_value}));

    task automatic send_req(input logic act, input logic [FRAME_W-1:0] frame,
                            input logic [ADDR_W-1:0] addr);
        if (idle_on)
            while ($urandom_range(99) < 37)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start         <= 1'b1;
        action        <= act;
        page_frame    <= frame;
        unmap_address <= addr;
        do
            @(posedge clk);
        while (busy);
        sb.accept_request(act, frame, addr);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [ADDR_W-1:0] base, input logic [FLAGS_W-1:0] flags);
        cfg_write <= 1'b1;
        cfg_index <= REG_WINDOW_BASE;
        cfg_data  <= base;
        @(posedge clk);
        sb.write_reg(REG_WINDOW_BASE, base);
        cfg_index <= REG_ENTRY_FLAGS;
        cfg_data  <= CFG_DATA_W'(flags);
        @(posedge clk);
        sb.write_reg(REG_ENTRY_FLAGS, CFG_DATA_W'(flags));
        cfg_write <= 1'b0;
    endtask

    task automatic random_regs();
        logic [ADDR_W-1:0]  base;
        logic [FLAGS_W-1:0] flags;
        case ($urandom_range(4))
            0: base = 32'h0000_0000;
            1: base = 32'hFFFF_FFFF;
            2: base = 32'hFFC0_0000;
            3: base = $urandom() & 32'hFFFF_F000;
            default: base = $urandom();
        endcase
        case ($urandom_range(2))
            0: flags = '0;
            1: flags = '1;
            default: flags = FLAGS_W'($urandom_range(4095));
        endcase
        write_regs(base, flags);
    endtask

    function automatic logic [FRAME_W-1:0] pick_frame();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return FRAME_W'($urandom_range(20'hFFFFF));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(int s);
        return sb.base + (ADDR_W'(s) << PAGE_BITS) + ADDR_W'($urandom_range(4095));
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            send_req(ACT_MAP, pick_frame(), $urandom());
        else if (r < 80)
            send_req(ACT_UNMAP, pick_frame(), slot_addr(sb.take_live()));
        else if (r < 92)
            send_req(ACT_UNMAP, pick_frame(), slot_addr($urandom_range(SLOT_COUNT - 1)));
        else
            send_req(ACT_UNMAP, pick_frame(), $urandom());
    endtask

    task automatic fill_window();
        int target;
        int n;
        target = sb.full_hits + 2;
        while (sb.full_hits < target)
            send_req(ACT_MAP, pick_frame(), $urandom());
        n = 8 + $urandom_range(8);
        repeat (n)
            send_req(ACT_UNMAP, pick_frame(), slot_addr(sb.take_live()));
        target = sb.full_hits + 1;
        while (sb.full_hits < target)
            send_req(ACT_MAP, pick_frame(), $urandom());
    endtask

    initial
    begin
        sb            = new();
        idle_on       = 1'b1;
        cycle_count   = 0;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        action        <= ACT_MAP;
        page_frame    <= '0;
        unmap_address <= '0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_WINDOW_BASE;
        cfg_data      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain window at zero
        write_regs(32'h0000_0000, 12'h000);
        send_req(ACT_MAP, 20'h00000, 32'h0000_0000);
        send_req(ACT_MAP, 20'hFFFFF, 32'hFFFF_FFFF);
        send_req(ACT_UNMAP, 20'hFFFFF, 32'h0000_0FFF);
        send_req(ACT_UNMAP, 20'h00000, 32'h0000_5000);
        send_req(ACT_UNMAP, 20'h00000, 32'h0040_0000);
        send_req(ACT_UNMAP, 20'h00000, 32'hFFFF_FFFF);
        send_req(ACT_UNMAP, 20'h00000, 32'h003F_F000);
        drain();

        // window that wraps past the top of the address space
        write_regs(32'hFFFF_F000, 12'hFFF);
        send_req(ACT_MAP, 20'h12345, 32'h0000_0000);
        send_req(ACT_MAP, 20'hFFFFF, 32'h0000_0000);
        send_req(ACT_UNMAP, 20'h00000, 32'hFFFF_F000);
        send_req(ACT_UNMAP, 20'h00000, 32'h0000_0000);
        send_req(ACT_UNMAP, 20'h00000, 32'hFFFF_EFFF);
        send_req(ACT_UNMAP, 20'h00000, 32'h003F_EFFF);
        send_req(ACT_UNMAP, 20'h00000, 32'h003F_F000);
        drain();

        // unaligned base
        write_regs(32'h1234_5678, 12'hA5A);
        send_req(ACT_MAP, 20'hABCDE, 32'h0000_0000);
        send_req(ACT_UNMAP, 20'h00000, 32'h1234_5678);
        send_req(ACT_UNMAP, 20'h00000, 32'h1234_5677);
        send_req(ACT_UNMAP, 20'h00000, 32'h1274_5677);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            random_regs();
            idle_on = (phase != 1);
            repeat (100) random_item();
            drain();
            if (phase == 2)
            begin
                random_regs();
                fill_window();
                drain();
            end
        end

        drain();
        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
